>>> hdl/mts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mts_pkg: shared types and codes of the MAC and tag session table
// Command and status codes, the stored key layout and the sequencer states.
// ---------------------------------------------------------------------------
package mts_pkg;

  localparam int MAC_W  = 48;
  localparam int TAG_W  = 32;
  localparam int SLOT_W = 4;

  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [TAG_W-1:0] tag;
  } key_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

endpackage

>>> hdl/mts_key_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mts_key_store: key memory of the session table
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module mts_key_store #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  mts_pkg::key_t     wr_key,
  input  logic [IDX_W-1:0]  rd_addr,
  output mts_pkg::key_t     rd_key
);

  mts_pkg::key_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= mem[rd_addr];
  end

endmodule

>>> hdl/mts_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mts_seq: scan sequencer of the session table
// Walks the key memory one slot a cycle through a single key comparator,
// tracks the first match and the lowest free slot, then commits and answers.
// ---------------------------------------------------------------------------
module mts_seq #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic [mts_pkg::MAC_W-1:0]  mac,
  input  logic [mts_pkg::TAG_W-1:0]  session_tag,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [mts_pkg::SLOT_W-1:0] slot,
  output logic                       wr_en,
  output logic [IDX_W-1:0]           wr_addr,
  output mts_pkg::key_t              wr_key,
  output logic [IDX_W-1:0]           rd_addr,
  input  mts_pkg::key_t              rd_key
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  mts_pkg::state_t state, state_next;

  logic [IDX_W-1:0]   cnt;
  logic               cmp_live;
  logic [IDX_W-1:0]   cmp_idx;
  logic [1:0]         cmd_r;
  mts_pkg::key_t      key_r;
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [ENTRIES-1:0] valid;

  logic                       accept;
  logic                       load;
  logic                       key_eq;
  logic                       do_set;
  logic                       do_clr;
  logic [1:0]                 res_status;
  logic [IDX_W-1:0]           res_idx;
  logic [IDX_W+mts_pkg::SLOT_W-1:0] res_ext;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mts_pkg::S_IDLE:   if (accept) state_next = mts_pkg::S_SCAN;
      mts_pkg::S_SCAN:   if (cnt == LAST) state_next = mts_pkg::S_DRAIN;
      mts_pkg::S_DRAIN:  state_next = mts_pkg::S_FINISH;
      mts_pkg::S_FINISH: if (load) state_next = mts_pkg::S_IDLE;
      default:           state_next = mts_pkg::S_IDLE;
    endcase
  end

  // Outputs and commit decisions
  always_comb begin
    in_ready   = (state == mts_pkg::S_IDLE);
    accept     = in_valid && in_ready;
    load       = (state == mts_pkg::S_FINISH) && (!out_valid || out_ready);
    key_eq     = (rd_key == key_r);
    do_set     = 1'b0;
    do_clr     = 1'b0;
    res_status = mts_pkg::ST_MISS;
    res_idx    = '0;
    unique case (cmd_r)
      mts_pkg::CMD_CREATE: begin
        if (!hit_found) begin
          if (free_found) begin
            do_set     = load;
            res_status = mts_pkg::ST_OK;
            res_idx    = free_idx;
          end else begin
            res_status = mts_pkg::ST_FULL;
          end
        end
      end
      mts_pkg::CMD_DELETE: begin
        if (hit_found) begin
          do_clr     = load;
          res_status = mts_pkg::ST_OK;
          res_idx    = hit_idx;
        end
      end
      mts_pkg::CMD_FIND: begin
        if (hit_found) begin
          res_status = mts_pkg::ST_OK;
          res_idx    = hit_idx;
        end
      end
      default: begin
        res_status = mts_pkg::ST_MISS;
      end
    endcase
    res_ext = {{mts_pkg::SLOT_W{1'b0}}, res_idx};
    wr_en   = do_set;
    wr_addr = free_idx;
    wr_key  = key_r;
    rd_addr = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mts_pkg::S_IDLE;
      cmp_live  <= 1'b0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cmp_live <= (state == mts_pkg::S_SCAN);
      if (do_set) valid[free_idx] <= 1'b1;
      if (do_clr) valid[hit_idx]  <= 1'b0;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cnt;
    if (accept) begin
      cmd_r      <= command;
      key_r.mac  <= mac;
      key_r.tag  <= session_tag;
      cnt        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (state == mts_pkg::S_SCAN && cnt != LAST) begin
        cnt <= cnt + 1'b1;
      end
      if (cmp_live) begin
        // keep the lowest slot of each kind
        if (valid[cmp_idx] && key_eq && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= cmp_idx;
        end
        if (!valid[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
    end
    if (load) begin
      status <= res_status;
      slot   <= res_ext[mts_pkg::SLOT_W-1:0];
    end
  end

  a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mts_pkg::ST_OK |-> slot == '0)
    else $error("nonzero slot on failed command");

  a_create_grows: assert property (@(posedge clk) disable iff (rst)
    do_set |=> $countones(valid) == $past($countones(valid)) + 1)
    else $error("create did not claim a free slot");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    do_clr |=> $countones(valid) == $past($countones(valid)) - 1)
    else $error("delete did not free a slot");

  a_hit_is_valid: assert property (@(posedge clk) disable iff (rst)
    state == mts_pkg::S_FINISH && hit_found |-> valid[hit_idx])
    else $error("match recorded on a free slot");

  a_drain_compares: assert property (@(posedge clk) disable iff (rst)
    state == mts_pkg::S_DRAIN |-> cmp_live && cmp_idx == LAST)
    else $error("last slot not compared");

endmodule

>>> hdl/mac_tag_session_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mac_tag_session_table_top: exact-match session table on MAC and tag
// Create, delete or find a session keyed by a 48-bit MAC and a 32-bit tag.
// ---------------------------------------------------------------------------
// A command is accepted, the scan then reads one slot per cycle as the key
// memory's single read port feeds the shared key comparator, the last slot
// is compared in the drain state, and the finish state commits and loads the
// result register. The input is taken again as soon as the result is loaded;
// a result that is still held when the next command finishes stalls that
// command until the beat is taken. Slot valid marks clear at reset, so no
// clearing pass is needed. A create on a full table answers status full; slot
// carries the low four bits of the slot index.
module mac_tag_session_table_top #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic [mts_pkg::MAC_W-1:0]  mac,
  input  logic [mts_pkg::TAG_W-1:0]  session_tag,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [mts_pkg::SLOT_W-1:0] slot
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  mts_pkg::key_t     wr_key;
  logic [IDX_W-1:0]  rd_addr;
  mts_pkg::key_t     rd_key;

  mts_key_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .rd_addr (rd_addr),
    .rd_key  (rd_key)
  );

  mts_seq #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .mac         (mac),
    .session_tag (session_tag),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot        (slot),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_key      (wr_key),
    .rd_addr     (rd_addr),
    .rd_key      (rd_key)
  );

endmodule
